>>> hw/rtl/sliding_window_max_min_sum_unit_macros.svh
// Assertion macros for the sliding window max/min/sum unit.
// Used by sliding_window_max_min_sum_unit.sv; expects clk and rst_n in scope.
`ifndef SLIDING_WINDOW_MAX_MIN_SUM_UNIT_MACROS_SVH
`define SLIDING_WINDOW_MAX_MIN_SUM_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define SWMMS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swmms assertion failed");

// Antecedent implies consequent in the next cycle.
`define SWMMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swmms assertion failed");

`else

`define SWMMS_ASSERT_SAME(label, ante, cons)
`define SWMMS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hw/rtl/swmms_pkg.sv
// Package for the sliding window max/min/sum unit: constants, types, states.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package swmms_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int TOTAL_BITS  = 48;
    localparam int CFG_BITS    = 7;

    localparam int SLOT_BITS = $clog2(WINDOW_MAX) > 0 ? $clog2(WINDOW_MAX) : 1;
    localparam int FILL_BITS = $clog2(WINDOW_MAX + 1);
    localparam int POS_BITS  = FILL_BITS;
    localparam int ADDR_BITS = SLOT_BITS + 1;
    localparam int MEM_DEPTH = 2 * (2 ** SLOT_BITS);
    localparam int CMP_BITS  = (CFG_BITS > FILL_BITS) ? CFG_BITS : FILL_BITS;
    localparam int SUM_BITS  = TOTAL_BITS + 1;

    // deque select
    localparam logic DQ_MAX = 1'b0;
    localparam logic DQ_MIN = 1'b1;

    localparam logic signed [TOTAL_BITS-1:0] TOTAL_HI = {1'b0, {(TOTAL_BITS-1){1'b1}}};
    localparam logic signed [TOTAL_BITS-1:0] TOTAL_LO = {1'b1, {(TOTAL_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic [POS_BITS-1:0]           pos;
    } swmms_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRONT_RD,
        ST_FRONT_CHK,
        ST_BACK_RD,
        ST_BACK_CHK,
        ST_PUSH,
        ST_FINISH
    } swmms_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/swmms_sample_if.sv
// Input channel interface: one sample per transaction.
// Depends on swmms_pkg.
`default_nettype none

interface swmms_sample_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [swmms_pkg::SAMPLE_BITS-1:0] sample;
    logic                                    last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/swmms_result_if.sv
// Result channel interface: one window result per transaction.
// Depends on swmms_pkg.
`default_nettype none

interface swmms_result_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     window_full;
    logic signed [swmms_pkg::SAMPLE_BITS-1:0] window_max;
    logic signed [swmms_pkg::SAMPLE_BITS-1:0] window_min;
    logic signed [swmms_pkg::TOTAL_BITS-1:0]  running_total;
    logic                                     total_saturated;

    modport source (output valid, output window_full, output window_max,
                    output window_min, output running_total, output total_saturated,
                    input ready);
    modport sink   (input valid, input window_full, input window_max,
                    input window_min, input running_total, input total_saturated,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/swmms_cfg_if.sv
// Configuration write channel interface: window size register.
// Depends on swmms_pkg.
`default_nettype none

interface swmms_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [swmms_pkg::CFG_BITS-1:0]    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sliding_window_max_min_sum_unit.sv
// Sliding window max/min/sum unit, top level.
// Depends on swmms_pkg, the three channel interfaces and the macros header.
`default_nettype none
`include "sliding_window_max_min_sum_unit_macros.svh"

// Usage
// - samples: one signed sample per transaction, last_sample closes a sequence.
// - results: one transaction per sample: window_full, window max and min
//   (zero until the window is full), saturating running total and its flag.
// - cfg: writes the window size (0 acts as 1, above WINDOW_MAX acts as
//   WINDOW_MAX). Always ready; write only while idle.
// Per sample: for each deque in turn (max, then min) the front entry is read and
// retired while it has aged out of the window, then back entries are read and
// popped while the new sample dominates them, then the sample is pushed; a final
// step writes the result register. Each front or back check waits on one read of
// the deque RAM, which has a registered read port. A new sample is taken only in
// the idle state, once the previous sample has been processed.
// Both deques share one 2*WINDOW_MAX entry RAM, one half per deque; the
// front value of each deque is kept in a register so no extra read is needed.
// The result register frees the input side: a new sample is taken while the
// previous result waits, and only the final step stalls on a held result.
// Reset: window size 1, deques empty, counters and total zero. No RAM clear.
// After a last_sample result all sequence state returns to that reset state.
module sliding_window_max_min_sum_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    swmms_sample_if.sink    samples,
    swmms_result_if.source  results,
    swmms_cfg_if.sink       cfg
);
    import swmms_pkg::*;

    // deque RAM: lower half max deque, upper half min deque
    swmms_entry_t mem [MEM_DEPTH];
    swmms_entry_t rd_data_reg;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    swmms_entry_t         wr_data;

    swmms_state_t state_reg, state_next;
    logic         sel_reg, sel_next;

    logic [SLOT_BITS-1:0]          head_reg  [2];
    logic [SLOT_BITS-1:0]          head_next [2];
    logic [FILL_BITS-1:0]          fill_reg  [2];
    logic [FILL_BITS-1:0]          fill_next [2];
    logic signed [SAMPLE_BITS-1:0] front_reg  [2];
    logic signed [SAMPLE_BITS-1:0] front_next [2];

    logic [POS_BITS-1:0]          pos_reg, pos_next;
    logic [FILL_BITS-1:0]         seen_reg, seen_next;
    logic signed [TOTAL_BITS-1:0] total_reg, total_next;
    logic                         sat_reg, sat_next;
    logic [CFG_BITS-1:0]          window_size_reg;

    // captured transaction
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          last_reg;

    // result register
    logic                          out_valid_reg, out_valid_next;
    logic                          out_full_reg, out_full_next;
    logic signed [SAMPLE_BITS-1:0] out_max_reg, out_max_next;
    logic signed [SAMPLE_BITS-1:0] out_min_reg, out_min_next;
    logic signed [TOTAL_BITS-1:0]  out_total_reg, out_total_next;
    logic                          out_sat_reg, out_sat_next;

    logic                 accept;
    logic                 commit;
    logic [SLOT_BITS-1:0] cur_head;
    logic [FILL_BITS-1:0] cur_fill;
    logic [SLOT_BITS-1:0] back_slot;
    logic [SLOT_BITS-1:0] push_slot;
    logic [POS_BITS-1:0]  age;
    logic                 dominated;
    logic [CMP_BITS-1:0]  cfg_wide;
    logic [FILL_BITS-1:0] w_eff;
    logic [FILL_BITS-1:0] seen_inc;
    logic                 full;
    logic signed [SUM_BITS-1:0] sum_wide;
    logic signed [TOTAL_BITS-1:0] sum_sat;
    logic                 sum_ovf;

    assign samples.ready = (state_reg == ST_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign cfg.ready     = 1'b1;

    assign results.valid           = out_valid_reg;
    assign results.window_full     = out_full_reg;
    assign results.window_max      = out_max_reg;
    assign results.window_min      = out_min_reg;
    assign results.running_total   = out_total_reg;
    assign results.total_saturated = out_sat_reg;

    // effective window length
    always_comb
    begin
        cfg_wide = CMP_BITS'(window_size_reg);
        if (cfg_wide == '0)
            w_eff = FILL_BITS'(1);
        else if (cfg_wide > CMP_BITS'(WINDOW_MAX))
            w_eff = FILL_BITS'(WINDOW_MAX);
        else
            w_eff = FILL_BITS'(cfg_wide);
    end

    assign cur_head  = head_reg[sel_reg];
    assign cur_fill  = fill_reg[sel_reg];
    assign back_slot = cur_head + cur_fill[SLOT_BITS-1:0] - SLOT_BITS'(1);
    assign push_slot = cur_head + cur_fill[SLOT_BITS-1:0];
    // ages stay at or below WINDOW_MAX, so modular position math is exact
    assign age       = pos_reg - rd_data_reg.pos;
    assign dominated = (sel_reg == DQ_MAX) ? (rd_data_reg.value <= sample_reg)
                                           : (rd_data_reg.value >= sample_reg);

    assign seen_inc = (seen_reg < FILL_BITS'(WINDOW_MAX)) ? seen_reg + FILL_BITS'(1)
                                                           : seen_reg;
    assign full     = (seen_inc >= w_eff);

    // max + min accumulate with clipping at the 48-bit bounds
    assign sum_wide = SUM_BITS'(total_reg) + SUM_BITS'(front_reg[DQ_MAX])
                    + SUM_BITS'(front_reg[DQ_MIN]);
    assign sum_ovf  = (sum_wide[SUM_BITS-1] != sum_wide[SUM_BITS-2]);
    assign sum_sat  = !sum_ovf ? sum_wide[TOTAL_BITS-1:0]
                    : (sum_wide[SUM_BITS-1] ? TOTAL_LO : TOTAL_HI);

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        front_next     = front_reg;
        pos_next       = pos_reg;
        seen_next      = seen_reg;
        total_next     = total_reg;
        sat_next       = sat_reg;
        out_full_next  = out_full_reg;
        out_max_next   = out_max_reg;
        out_min_next   = out_min_reg;
        out_total_next = out_total_reg;
        out_sat_next   = out_sat_reg;
        rd_en          = 1'b0;
        rd_addr        = {sel_reg, cur_head};
        wr_en          = 1'b0;
        wr_addr        = {sel_reg, push_slot};
        wr_data.value  = sample_reg;
        wr_data.pos    = pos_reg;
        commit         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_FRONT_RD;
                    sel_next   = DQ_MAX;
                end
            end
            ST_FRONT_RD:
            begin
                if (cur_fill == '0)
                    state_next = ST_PUSH;
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_FRONT_CHK;
                end
            end
            ST_FRONT_CHK:
            begin
                if (age >= w_eff)
                begin
                    head_next[sel_reg] = cur_head + SLOT_BITS'(1);
                    fill_next[sel_reg] = cur_fill - FILL_BITS'(1);
                    state_next         = ST_FRONT_RD;
                end
                else
                begin
                    // surviving head is the window extreme unless popped below
                    front_next[sel_reg] = rd_data_reg.value;
                    state_next          = ST_BACK_RD;
                end
            end
            ST_BACK_RD:
            begin
                if (cur_fill == '0)
                    state_next = ST_PUSH;
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = {sel_reg, back_slot};
                    state_next = ST_BACK_CHK;
                end
            end
            ST_BACK_CHK:
            begin
                if (dominated)
                begin
                    fill_next[sel_reg] = cur_fill - FILL_BITS'(1);
                    state_next         = ST_BACK_RD;
                end
                else
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                wr_en              = 1'b1;
                fill_next[sel_reg] = cur_fill + FILL_BITS'(1);
                if (cur_fill == '0)
                    front_next[sel_reg] = sample_reg;
                if (sel_reg == DQ_MAX)
                begin
                    sel_next   = DQ_MIN;
                    state_next = ST_FRONT_RD;
                end
                else
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    commit         = 1'b1;
                    state_next     = ST_IDLE;
                    out_full_next  = full;
                    out_max_next   = full ? front_reg[DQ_MAX] : '0;
                    out_min_next   = full ? front_reg[DQ_MIN] : '0;
                    out_total_next = full ? sum_sat : total_reg;
                    out_sat_next   = sat_reg || (full && sum_ovf);
                    if (last_reg)
                    begin
                        head_next  = '{default: '0};
                        fill_next  = '{default: '0};
                        pos_next   = '0;
                        seen_next  = '0;
                        total_next = '0;
                        sat_next   = 1'b0;
                    end
                    else
                    begin
                        pos_next   = pos_reg + POS_BITS'(1);
                        seen_next  = seen_inc;
                        total_next = full ? sum_sat : total_reg;
                        sat_next   = sat_reg || (full && sum_ovf);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (commit)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            sel_reg         <= DQ_MAX;
            head_reg        <= '{default: '0};
            fill_reg        <= '{default: '0};
            pos_reg         <= '0;
            seen_reg        <= '0;
            total_reg       <= '0;
            sat_reg         <= 1'b0;
            window_size_reg <= CFG_BITS'(1);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            total_reg     <= total_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
                window_size_reg <= cfg.data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        front_reg      <= front_next;
        out_full_reg   <= out_full_next;
        out_max_reg    <= out_max_next;
        out_min_reg    <= out_min_next;
        out_total_reg  <= out_total_next;
        out_sat_reg    <= out_sat_next;
        if (accept)
        begin
            sample_reg <= samples.sample;
            last_reg   <= samples.last_sample;
        end
    end

    // deque RAM, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // a push never overwrites a live entry
    `SWMMS_ASSERT_SAME(a_push_room, state_reg == ST_PUSH, cur_fill < FILL_BITS'(WINDOW_MAX))
    // no read and write of the same entry in one cycle
    `SWMMS_ASSERT_SAME(a_no_rw_clash, rd_en && wr_en, rd_addr != wr_addr)
    // a new sample always starts on the max deque
    `SWMMS_ASSERT_NEXT(a_start_max, accept, state_reg == ST_FRONT_RD && sel_reg == DQ_MAX)
    // end of sequence leaves both deques empty and counters cleared
    `SWMMS_ASSERT_NEXT(a_last_clears, commit && last_reg,
                       fill_reg[0] == '0 && fill_reg[1] == '0 && pos_reg == '0 && !sat_reg)

endmodule

`default_nettype wire
